// ===== src/button_debounce_long_press_defines.svh =====
// ----------------------------------------------------------------------------
// button debounce assertion macros
// shared property forms for the debounce block's checks
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BDLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types, constants and helpers of the button debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int IN_BYTES_W  = 8;
  localparam int OUT_BYTES_W = 8;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(40);
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(1000);

  typedef enum logic [0:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic raw_level;
    logic read_press_flag;
  } item_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_press_event;
    logic stable_level;
    logic press_flag_value;
  } result_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// tick-driven push button debouncer with press, release and long-press events
// ----------------------------------------------------------------------------
//  channel  | signals                        | carries
//  ---------+--------------------------------+-------------------------------
//  s_axis   | s_tvalid s_tready s_tdata[7:0] | one sampled tick per transfer
//  m_axis   | m_tvalid m_tready m_tdata[7:0] | one result per input transfer
//  cfg      | cfg_we cfg_addr cfg_data       | setting writes, no read-back
//
//  one transfer per cycle while the m side accepts; from s to m an item passes
//  the input register, then the event logic into the result register
//  state is updated as an item moves from the input register to the result
//  register, so a stalled m side holds both stages and drops s_tready
//  synchronous reset restores settings 40 and 1000 and a released button
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [0] raw_level, [1] read_press_flag, [7:2] zero
  input  wire logic [IN_BYTES_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [0] press_event, [1] release_event, [2] long_press_event,
  // [3] stable_level, [4] press_flag_value, [7:5] zero
  output logic [OUT_BYTES_W-1:0]      m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_addr,
  input  wire logic [CFG_WIDTH-1:0]   cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  bdlp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.raw_level       <= s_tdata[0];
      in_item.read_press_flag <= s_tdata[1];
    end
  end

  bdlp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_item),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.press_flag_value, out_res.stable_level,
                    out_res.long_press_event, out_res.release_event,
                    out_res.press_event};

`include "button_debounce_long_press_defines.svh"

  // an event must agree with the stable level it reports
  `BDLP_ASSERT_IMP(a_press_level, m_tvalid && (out_res.press_event || out_res.long_press_event), !out_res.stable_level, "press event with released stable level")
  `BDLP_ASSERT_IMP(a_release_level, m_tvalid && out_res.release_event, out_res.stable_level && !out_res.press_event, "release event inconsistent")
  // a full pipe with a stalled result side must not take a transfer
  `BDLP_ASSERT_IMP(a_no_overrun, in_valid && m_tvalid && !m_tready, !s_tready, "input taken while both stages are full")
  // the sticky flag is reported with any press
  `BDLP_ASSERT_IMP(a_flag_on_press, m_tvalid && out_res.press_event, out_res.press_flag_value, "press without sticky flag")

endmodule

`default_nettype wire

// ===== src/bdlp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// debounce and long-press setting registers behind the write port
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_cfg_regs
  import bdlp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_addr,
  input  wire logic [CFG_WIDTH-1:0] cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ticks <= cfg_data;
        default:        ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bdlp_core.sv =====
// ----------------------------------------------------------------------------
// bdlp_core
// debounce state and event logic, one item per advance
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_core
  import bdlp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    advance,
  input  wire item_t   item,
  output result_t      res
);

  logic                   debounced_level, debounced_level_next;
  logic                   previous_raw;
  logic [COUNT_WIDTH-1:0] since_change, since_change_next;
  logic [COUNT_WIDTH-1:0] press_duration, press_duration_next;
  logic                   long_reported, long_reported_next;
  logic                   sticky_pressed, sticky_pressed_next;

  logic [COUNT_WIDTH-1:0] pd_run;
  logic                   accept_level;
  logic                   sticky_set;
  logic                   long_hit;

  always_comb begin
    // press time counts while the old stable level is pressed
    pd_run = (debounced_level == 1'b0) ? sat_inc(press_duration) : press_duration;

    since_change_next = (item.raw_level != previous_raw) ? '0 : sat_inc(since_change);

    accept_level = (CMP_WIDTH'(since_change_next) > CMP_WIDTH'(cfg.debounce_ticks))
                   && (item.raw_level != debounced_level);

    debounced_level_next = accept_level ? item.raw_level : debounced_level;
    press_duration_next  = accept_level ? '0 : pd_run;
    sticky_set           = accept_level && (item.raw_level == 1'b0);
    sticky_pressed_next  = sticky_set | sticky_pressed;

    long_hit = (debounced_level_next == 1'b0)
               && !(long_reported && !accept_level)
               && (CMP_WIDTH'(press_duration_next) >= CMP_WIDTH'(cfg.long_press_ticks));
    long_reported_next = accept_level ? long_hit : (long_reported | long_hit);

    res.press_event      = sticky_set;
    res.release_event    = accept_level && item.raw_level;
    res.long_press_event = long_hit;
    res.stable_level     = debounced_level_next;
    res.press_flag_value = sticky_pressed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_level <= 1'b1;
      previous_raw    <= 1'b1;
      since_change    <= '0;
      press_duration  <= '0;
      long_reported   <= 1'b0;
      sticky_pressed  <= 1'b0;
    end else if (advance) begin
      debounced_level <= debounced_level_next;
      previous_raw    <= item.raw_level;
      since_change    <= since_change_next;
      press_duration  <= press_duration_next;
      long_reported   <= long_reported_next;
      // read strobe clears after the value is reported
      sticky_pressed  <= item.read_press_flag ? 1'b0 : sticky_pressed_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/bdlp_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdlp_event_checker
// watches the tick, result and setting channels of the button debouncer,
// predicts each result from its own copy of the debounce state and compares
// the results field by field in order
// ----------------------------------------------------------------------------

module bdlp_event_checker
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_BYTES_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_addr,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  output int                     pending,
  output int                     failures
);

  // settings as seen on the write port
  logic [CFG_WIDTH-1:0]   debounce_set;
  logic [CFG_WIDTH-1:0]   long_press_set;

  // debounce state
  logic                   stable_q;
  logic                   last_raw_q;
  logic [COUNT_WIDTH-1:0] since_change_q;
  logic [COUNT_WIDTH-1:0] held_ticks_q;
  logic                   long_done_q;
  logic                   press_latch_q;

  result_t                expected_events[$];
  int                     mismatch_count = 0;

  assign pending  = expected_events.size();
  assign failures = mismatch_count;

  function automatic result_t step_button(input item_t tick);
    result_t r;
    r = '0;
    if (!stable_q && held_ticks_q != CNT_MAX) held_ticks_q = held_ticks_q + 1'b1;
    if (tick.raw_level != last_raw_q) begin
      since_change_q = '0;
      last_raw_q     = tick.raw_level;
    end else if (since_change_q != CNT_MAX) begin
      since_change_q = since_change_q + 1'b1;
    end
    if (since_change_q > debounce_set && tick.raw_level != stable_q) begin
      stable_q     = tick.raw_level;
      held_ticks_q = '0;
      long_done_q  = 1'b0;
      if (!tick.raw_level) begin
        press_latch_q = 1'b1;
        r.press_event = 1'b1;
      end else begin
        r.release_event = 1'b1;
      end
    end
    if (!stable_q && !long_done_q && held_ticks_q >= long_press_set) begin
      long_done_q        = 1'b1;
      r.long_press_event = 1'b1;
    end
    r.stable_level     = stable_q;
    // flag is reported before the read clears it
    r.press_flag_value = press_latch_q;
    if (tick.read_press_flag) press_latch_q = 1'b0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t   tick;
    result_t want;
    if (rst) begin
      debounce_set   = DEBOUNCE_RESET;
      long_press_set = LONG_PRESS_RESET;
      stable_q       = 1'b1;
      last_raw_q     = 1'b1;
      since_change_q = '0;
      held_ticks_q   = '0;
      long_done_q    = 1'b0;
      press_latch_q  = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_addr))
          REG_DEBOUNCE:   debounce_set   = cfg_data;
          REG_LONG_PRESS: long_press_set = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        tick.raw_level       = s_tdata[0];
        tick.read_press_flag = s_tdata[1];
        expected_events.push_back(step_button(tick));
      end
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          $error("result transfer with no expected result, data %0h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("press_event",      want.press_event,      m_tdata[0]);
          check_field("release_event",    want.release_event,    m_tdata[1]);
          check_field("long_press_event", want.long_press_event, m_tdata[2]);
          check_field("stable_level",     want.stable_level,     m_tdata[3]);
          check_field("press_flag_value", want.press_flag_value, m_tdata[4]);
        end
      end
    end
  end

endmodule

// ===== verif/button_debounce_long_press_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// drives sampled ticks into the debouncer under several settings and idle
// patterns, including edge settings at both ends of the range; the checker
// predicts and compares every result, this module gives the verdict
// ----------------------------------------------------------------------------

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_BYTES_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_BYTES_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [0:0]             cfg_addr = REG_DEBOUNCE;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;

  int pending;
  int failures;

  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int ticks_sent = 0;

  always #2 clk = ~clk;

  button_debounce_long_press dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  bdlp_event_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .pending  (pending),
    .failures (failures)
  );

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready   <= 1'b0;
      stall_left <= 300;
      hold_done  <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_tick(input logic raw, input logic rd);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_BYTES_W'({rd, raw});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // wait for the block to go idle, then write both settings
  task automatic reconfigure(input logic [CFG_WIDTH-1:0] deb,
                             input logic [CFG_WIDTH-1:0] lp);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_addr <= REG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // bounce bursts followed by a stable hold, with some stray ticks mixed in
  task automatic random_stream(input int count, input int span);
    int   stop;
    int   len;
    logic lvl;
    stop = ticks_sent + count;
    while (ticks_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        send_tick($urandom_range(1), $urandom_range(1));
      end else begin
        lvl = $urandom_range(1);
        repeat ($urandom_range(3)) begin
          len = $urandom_range(1, 3);
          repeat (len) send_tick(~lvl, $urandom_range(3) == 0);
          send_tick(lvl, $urandom_range(3) == 0);
        end
        len = $urandom_range(0, span);
        repeat (len) send_tick(lvl, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    int deb;
    int lp;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: short bounces never get accepted
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // zero debounce and zero long press: long press lands with the press,
    // and a read on the press tick returns the flag and clears it
    reconfigure(16'd0, 16'd0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);

    reconfigure(16'd2, 16'd3);
    repeat (9) send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b1);

    // no idling, with one long receiver hold-off to back up the pipeline
    reconfigure(16'd0, 16'd1);
    stall_pct <= 0;
    hold_req  <= 1'b1;
    random_stream(250, 6);

    deb = $urandom_range(1, 6);
    lp  = $urandom_range(2, 20);
    reconfigure(deb[CFG_WIDTH-1:0], lp[CFG_WIDTH-1:0]);
    idle_pct = 46;
    random_stream(250, deb + lp + 4);

    deb = $urandom_range(0, 6);
    lp  = $urandom_range(1, 20);
    reconfigure(deb[CFG_WIDTH-1:0], lp[CFG_WIDTH-1:0]);
    idle_pct = 0;
    stall_pct <= 46;
    random_stream(250, deb + lp + 4);

    deb = $urandom_range(0, 8);
    lp  = $urandom_range(1, 30);
    reconfigure(deb[CFG_WIDTH-1:0], lp[CFG_WIDTH-1:0]);
    idle_pct = 31;
    stall_pct <= 31;
    random_stream(250, deb + lp + 4);

    // top settings: nothing is accepted within a short run
    reconfigure(16'hFFFF, 16'hFFFF);
    idle_pct = 0;
    stall_pct <= 0;
    repeat (6) send_tick(1'b0, 1'b1);
    repeat (6) send_tick(1'b1, 1'b0);

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
